FILE: rtl/ham6enc_pkg.sv
// Shared types, constants and helpers for the HAM6 pixel encoder.
package ham6enc_pkg;

	// number of palette entries searched, 1 to 16
	localparam int PAL_ENTRIES = 16;
	localparam int IDX_W = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;

	localparam int NIB_W = 4;
	localparam int DIST_W = 6;
	localparam int PEN_W = 6;
	localparam int ENTRY_W = 12;
	localparam int WORD_W = 48;
	localparam int ENTRIES_PER_WORD = WORD_W / ENTRY_W;
	localparam int NUM_WORDS = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [PEN_W-1:0] PEN_BLUE = 6'h10;
	localparam logic [PEN_W-1:0] PEN_RED = 6'h20;
	localparam logic [PEN_W-1:0] PEN_GREEN = 6'h30;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAL_ENABLE = 3'd0,
		REG_PAL_WORDS_A = 3'd1,
		REG_PAL_WORDS_B = 3'd2,
		REG_PAL_WORDS_C = 3'd3,
		REG_PAL_WORDS_D = 3'd4
	} cfg_reg_t;

	// one pipeline word travelling down the palette search chain
	typedef struct packed {
		logic valid;
		logic [NIB_W-1:0] red;
		logic [NIB_W-1:0] green;
		logic [NIB_W-1:0] blue;
		logic line_start;
		logic found;
		logic [DIST_W-1:0] diff_sum;
		logic [IDX_W-1:0] idx;
	} stage_word_t;

	function automatic logic [NIB_W-1:0] absdiff4(input logic [NIB_W-1:0] a,
			input logic [NIB_W-1:0] b);
		absdiff4 = (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

FILE: rtl/ham6enc_pal_cell.sv
// One palette search cell: compares the pixel with one entry and keeps the best so far.
module ham6enc_pal_cell (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic [ham6enc_pkg::IDX_W-1:0] entry_idx,
	input logic [ham6enc_pkg::ENTRY_W-1:0] entry,
	input ham6enc_pkg::stage_word_t prev,
	output ham6enc_pkg::stage_word_t nxt
);

	logic [ham6enc_pkg::DIST_W-1:0] diff_sum;
	logic take;
	ham6enc_pkg::stage_word_t upd;
	ham6enc_pkg::stage_word_t word_s1;

	always_comb begin
		diff_sum = {2'b00, ham6enc_pkg::absdiff4(entry[11:8], prev.red)}
			+ {2'b00, ham6enc_pkg::absdiff4(entry[7:4], prev.green)}
			+ {2'b00, ham6enc_pkg::absdiff4(entry[3:0], prev.blue)};
		// strict compare keeps the lowest index on ties
		take = !prev.found || (diff_sum < prev.diff_sum);
		upd = prev;
		if (take) begin
			upd.found = 1'b1;
			upd.diff_sum = diff_sum;
			upd.idx = entry_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_s1 <= '0;
		end else if (advance) begin
			word_s1 <= upd;
		end
	end

	assign nxt = word_s1;

endmodule

FILE: rtl/ham6enc_hold_stage.sv
// Final stage: held colour, hold-and-modify choice against palette best, output register.
module ham6enc_hold_stage (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic pal_en,
	input ham6enc_pkg::stage_word_t word_in,
	input logic [ham6enc_pkg::ENTRY_W-1:0] pal_color,
	output logic out_valid,
	output logic [ham6enc_pkg::PEN_W-1:0] pen_code
);

	logic [ham6enc_pkg::NIB_W-1:0] held_red_q, held_green_q, held_blue_q;
	logic [ham6enc_pkg::NIB_W-1:0] cur_red, cur_green, cur_blue;
	logic [ham6enc_pkg::NIB_W-1:0] rd, gd, bd, mx;
	logic [ham6enc_pkg::DIST_W-1:0] ham_err;
	logic red_wins, green_wins, use_pal;
	logic [ham6enc_pkg::NIB_W-1:0] nxt_red, nxt_green, nxt_blue;
	logic [ham6enc_pkg::PEN_W-1:0] pen;
	logic valid_q;
	logic [ham6enc_pkg::PEN_W-1:0] pen_q;

	always_comb begin
		// line start: held colour is black for this pixel
		cur_red = word_in.line_start ? '0 : held_red_q;
		cur_green = word_in.line_start ? '0 : held_green_q;
		cur_blue = word_in.line_start ? '0 : held_blue_q;
		rd = ham6enc_pkg::absdiff4(cur_red, word_in.red);
		gd = ham6enc_pkg::absdiff4(cur_green, word_in.green);
		bd = ham6enc_pkg::absdiff4(cur_blue, word_in.blue);
		red_wins = (rd >= gd) && (rd >= bd);
		green_wins = (gd >= bd);
		mx = red_wins ? rd : (green_wins ? gd : bd);
		ham_err = {2'b00, rd} + {2'b00, gd} + {2'b00, bd} - {2'b00, mx};
		use_pal = pal_en && word_in.found && (word_in.diff_sum < ham_err);
		nxt_red = cur_red;
		nxt_green = cur_green;
		nxt_blue = cur_blue;
		if (use_pal) begin
			pen = {{(ham6enc_pkg::PEN_W-ham6enc_pkg::IDX_W){1'b0}}, word_in.idx};
			nxt_red = pal_color[11:8];
			nxt_green = pal_color[7:4];
			nxt_blue = pal_color[3:0];
		end else if (red_wins) begin
			pen = ham6enc_pkg::PEN_RED | {2'b00, word_in.red};
			nxt_red = word_in.red;
		end else if (green_wins) begin
			pen = ham6enc_pkg::PEN_GREEN | {2'b00, word_in.green};
			nxt_green = word_in.green;
		end else begin
			pen = ham6enc_pkg::PEN_BLUE | {2'b00, word_in.blue};
			nxt_blue = word_in.blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_red_q <= '0;
			held_green_q <= '0;
			held_blue_q <= '0;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= word_in.valid;
			if (word_in.valid) begin
				held_red_q <= nxt_red;
				held_green_q <= nxt_green;
				held_blue_q <= nxt_blue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pen_q <= pen;
		end
	end

	assign out_valid = valid_q;
	assign pen_code = pen_q;

endmodule

FILE: rtl/ham6_pixel_encoder_unit.sv
// HAM6 pixel encoder top level: config registers, palette search chain, hold stage.
//
// Input channel: one pixel word per accepted handshake (in_valid high, in_stall low):
// red/green/blue samples (top nibble used) and line_start, which blacks out the held
// colour before that pixel. Output channel: one 6-bit pen_code word per pixel, in order.
// Throughput is one pixel per cycle while no result waits stalled. There is one search
// cell per palette entry, then the hold stage that closes the held-colour loop and
// fills the output register.
// When the receiver stalls, the output word holds and the whole chain freezes;
// in_stall is raised only while a result waits stalled, so a new pixel is still taken
// whenever the output register is empty or being drained.
// Reset clears the held colour, the palette registers, palette_enable and all word
// valids. Configuration (cfg_write_enable, cfg_index, cfg_data) takes effect at once
// and is meant to be written with the pipeline empty; indexes past the list are ignored.
module ham6_pixel_encoder_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] red_sample,
	input logic [7:0] green_sample,
	input logic [7:0] blue_sample,
	input logic line_start,
	output logic out_valid,
	input logic out_stall,
	output logic [ham6enc_pkg::PEN_W-1:0] pen_code,
	input logic cfg_write_enable,
	input logic [ham6enc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ham6enc_pkg::WORD_W-1:0] cfg_data
);

	logic pal_en_q;
	logic [ham6enc_pkg::WORD_W-1:0] pal_words_q [ham6enc_pkg::NUM_WORDS];
	logic [ham6enc_pkg::ENTRY_W-1:0] pal_entry [ham6enc_pkg::PAL_ENTRIES];
	ham6enc_pkg::stage_word_t chain [ham6enc_pkg::PAL_ENTRIES+1];
	ham6enc_pkg::stage_word_t last_word;
	logic advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_en_q <= 1'b0;
			for (int i = 0; i < ham6enc_pkg::NUM_WORDS; i++) begin
				pal_words_q[i] <= '0;
			end
		end else if (cfg_write_enable) begin
			unique case (cfg_index)
				ham6enc_pkg::REG_PAL_ENABLE: pal_en_q <= cfg_data[0];
				ham6enc_pkg::REG_PAL_WORDS_A: pal_words_q[0] <= cfg_data;
				ham6enc_pkg::REG_PAL_WORDS_B: pal_words_q[1] <= cfg_data;
				ham6enc_pkg::REG_PAL_WORDS_C: pal_words_q[2] <= cfg_data;
				ham6enc_pkg::REG_PAL_WORDS_D: pal_words_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar k = 0; k < ham6enc_pkg::PAL_ENTRIES; k++) begin : g_entry
		assign pal_entry[k] = pal_words_q[k / ham6enc_pkg::ENTRIES_PER_WORD]
			[(k % ham6enc_pkg::ENTRIES_PER_WORD) * ham6enc_pkg::ENTRY_W +: ham6enc_pkg::ENTRY_W];
	end

	// whole chain moves unless a finished word sits stalled at the output
	assign advance = !out_valid || !out_stall;
	assign in_stall = !advance;

	always_comb begin
		chain[0] = '0;
		chain[0].valid = in_valid;
		chain[0].red = red_sample[7:4];
		chain[0].green = green_sample[7:4];
		chain[0].blue = blue_sample[7:4];
		chain[0].line_start = line_start;
	end

	for (genvar k = 0; k < ham6enc_pkg::PAL_ENTRIES; k++) begin : g_cell
		ham6enc_pal_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.advance(advance),
			.entry_idx(ham6enc_pkg::IDX_W'(k)),
			.entry(pal_entry[k]),
			.prev(chain[k]),
			.nxt(chain[k+1])
		);
	end

	// the hold stage loads the chosen entry's colour when the palette wins
	ham6enc_pkg::stage_word_t tail;
	logic [ham6enc_pkg::ENTRY_W-1:0] chosen_color;
	ham6enc_pkg::stage_word_t hold_word;

	assign tail = chain[ham6enc_pkg::PAL_ENTRIES];
	assign chosen_color = pal_entry[tail.idx];

	ham6enc_hold_stage u_hold (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.pal_en(pal_en_q),
		.word_in(hold_word),
		.pal_color(chosen_color),
		.out_valid(out_valid),
		.pen_code(pen_code)
	);

	assign last_word = tail;

	always_comb begin
		hold_word = last_word;
	end

endmodule

FILE: rtl/ham6enc_checker.sv
// Port-level checks for the HAM6 pixel encoder, bound to the top level.
module ham6enc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [ham6enc_pkg::PEN_W-1:0] pen_code
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pen_code))
		else $error("stalled output word changed");

	// input backpressure only while a result waits stalled
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output word");

	// reset empties the output register
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output word valid after reset");

	// an empty output register never stalls the input
	a_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

endmodule

bind ham6_pixel_encoder_unit ham6enc_checker u_ham6enc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.pen_code(pen_code)
);
